// ===== rtl/core/apf_pkg.sv =====
// Package: shared constants and types for the articulation point finder.
package apf_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VtxW        = 6;
  localparam int unsigned CntW        = 7;

  localparam logic CmdAddEdge = 1'b0;
  localparam logic CmdRun     = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StEdgeA,
    StEdgeB,
    StRootScan,
    StScan,
    StBack,
    StFold,
    StEmit,
    StWipe
  } state_e;

endpackage

// ===== rtl/core/articulation_point_finder.sv =====
// Top level: articulation point (cut vertex) finder over a loaded graph.
//
// Edge items (command 0) go through StEdgeA and StEdgeB before ready returns:
// the accept cycle reads row A of the adjacency memory, StEdgeA writes it back
// with bit B set while reading row B, and StEdgeB writes row B with bit A.
// A run item (command 1) does an iterative depth-first search. The stack is
// implied by parent links: the vertex under the top is always the top's
// parent. Each scan cycle finds the next neighbor of the top vertex at or
// after its resume position in one priority pick; a tree edge steps down in
// that cycle, a back edge goes through StBack to fetch the neighbor's
// discovery time, and a finished non-root vertex goes through StFold to fold
// its low time into the parent. A run then sends one result beat per cycle
// while out_ready_i is high, followed by a wipe of all MAX_VERTICES rows that
// clears the adjacency memory. After reset the adjacency memory is cleared by
// a pass over all MAX_VERTICES rows during which no item is accepted. Results
// come out in ascending vertex order with the run's cut count; a graph without
// cut vertices yields one beat with found low. vertex_count may be written only
// while the block is idle.
module articulation_point_finder #(
  parameter int unsigned MAX_VERTICES = apf_pkg::MaxVertices
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [apf_pkg::CntW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      command_i,
  input  logic [apf_pkg::VtxW-1:0]  end_a_i,
  input  logic [apf_pkg::VtxW-1:0]  end_b_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [apf_pkg::VtxW-1:0]  cut_vertex_o,
  output logic                      found_o,
  output logic [apf_pkg::CntW-1:0]  cut_count_o,
  output logic                      last_o
);
  import apf_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
  localparam logic [NW-1:0] NMax = NW'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] Bit0 = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
  localparam logic [1:0] KidsMany = 2'd2;   // tree child count saturates here

  // vertex_count register, saturated to MAX_VERTICES on use
  logic [CntW-1:0] vcount_q;
  logic [NW-1:0]   n_eff;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vcount_q <= CntW'(MaxVertices);
    else if (cfg_we_i) vcount_q <= cfg_wdata_i;
  end
  assign n_eff = (32'(vcount_q) > MAX_VERTICES) ? NMax : NW'(vcount_q);

  // adjacency memory, one row per vertex
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [AW-1:0]           adj_raddr;
  logic [MAX_VERTICES-1:0] adj_rdata_q;
  logic                    adj_we;
  logic [AW-1:0]           adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_rdata_q <= adj_mem[adj_raddr];
  end

  // per-vertex record memory: disc, low, parent, scan resume point, child count
  typedef struct packed {
    logic [VtxW-1:0] disc;
    logic [VtxW-1:0] low;
    logic [AW-1:0]   parent;
    logic            has_par;
    logic [NW-1:0]   scan;
    logic [1:0]      kids;
  } rec_t;
  rec_t          rec_mem [MAX_VERTICES];
  logic [AW-1:0] rec_raddr;
  rec_t          rec_rdata_q;
  logic          rec_we;
  logic [AW-1:0] rec_waddr;
  rec_t          rec_wdata;
  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    rec_rdata_q <= rec_mem[rec_raddr];
  end

  logic [MAX_VERTICES-1:0] vis_q, vis_d, cut_q, cut_d;

  state_e          state_q, state_d;
  logic [NW-1:0]   idx_q, idx_d;        // root / emit / wipe index
  logic [CntW-1:0] time_q, time_d;
  logic [CntW-1:0] cnt_q, cnt_d;        // cut vertices flagged so far
  logic [AW-1:0]   ea_q, ea_d, eb_q, eb_d;
  logic            edge_ok_q, edge_ok_d;
  logic [AW-1:0]   top_q, top_d;        // vertex on top of the search
  rec_t            cur_q, cur_d;        // its live record
  logic [VtxW-1:0] chd_low_q, chd_low_d; // low time of a finished child
  logic [AW-1:0]   chv_q, chv_d;        // back-edge neighbor
  logic            ov_q, ov_d;
  logic [VtxW-1:0] ocv_q, ocv_d;
  logic            ofd_q, ofd_d, olast_q, olast_d;
  logic [CntW-1:0] ocnt_q, ocnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; idx_q <= '0; time_q <= '0; cnt_q <= '0;
      ea_q <= '0; eb_q <= '0; edge_ok_q <= 1'b0; top_q <= '0; cur_q <= '0;
      chd_low_q <= '0; chv_q <= '0; vis_q <= '0; cut_q <= '0;
      ov_q <= 1'b0; ocv_q <= '0; ofd_q <= 1'b0; olast_q <= 1'b0; ocnt_q <= '0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; time_q <= time_d; cnt_q <= cnt_d;
      ea_q <= ea_d; eb_q <= eb_d; edge_ok_q <= edge_ok_d; top_q <= top_d;
      cur_q <= cur_d; chd_low_q <= chd_low_d; chv_q <= chv_d;
      vis_q <= vis_d; cut_q <= cut_d;
      ov_q <= ov_d; ocv_q <= ocv_d; ofd_q <= ofd_d; olast_q <= olast_d;
      ocnt_q <= ocnt_d;
    end
  end

  // bits at or above position s
  function automatic logic [MAX_VERTICES-1:0] from_pos(input logic [NW-1:0] s);
    logic [MAX_VERTICES-1:0] m;
    for (int i = 0; i < MAX_VERTICES; i++) m[i] = (NW'(i) >= s);
    return m;
  endfunction

  // lowest set bit
  function automatic logic [AW-1:0] first_set(input logic [MAX_VERTICES-1:0] v);
    logic [AW-1:0] r;
    r = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) if (v[i]) r = AW'(i);
    return r;
  endfunction

  logic [MAX_VERTICES-1:0] nmask, par_bit, scan_cand, emit_cand, emit_rest;
  logic [AW-1:0]           f_scan, f_emit, idx_v;
  logic [NW-1:0]           scan_next;
  logic [VtxW-1:0]         disc_u;
  logic                    out_take;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) nmask[i] = (NW'(i) < n_eff);
  end

  // the parent edge is never taken back up
  assign par_bit   = cur_q.has_par ? (Bit0 << cur_q.parent) : '0;
  assign scan_cand = adj_rdata_q & nmask & from_pos(cur_q.scan) & ~par_bit;
  assign f_scan    = first_set(scan_cand);
  assign scan_next = NW'(f_scan) + NW'(1);
  assign emit_cand = cut_q & from_pos(idx_q);
  assign f_emit    = first_set(emit_cand);
  assign emit_rest = emit_cand & ~(Bit0 << f_emit);
  assign idx_v     = AW'(idx_q);
  assign out_take  = ov_q && out_ready_i;
  // self loop: the top's record is still in cur_q
  assign disc_u    = (chv_q == top_q) ? cur_q.disc : rec_rdata_q.disc;

  always_comb begin
    state_d = state_q; idx_d = idx_q; time_d = time_q; cnt_d = cnt_q;
    ea_d = ea_q; eb_d = eb_q; edge_ok_d = edge_ok_q; top_d = top_q;
    cur_d = cur_q; chd_low_d = chd_low_q; chv_d = chv_q;
    vis_d = vis_q; cut_d = cut_q;
    ov_d = ov_q; ocv_d = ocv_q; ofd_d = ofd_q; olast_d = olast_q; ocnt_d = ocnt_q;
    adj_raddr = top_q; adj_we = 1'b0; adj_waddr = idx_v; adj_wdata = '0;
    rec_raddr = top_q; rec_we = 1'b0; rec_waddr = top_q; rec_wdata = cur_q;
    in_ready_o = 1'b0;
    if (out_take) ov_d = 1'b0;

    unique case (state_q)
      StClear, StWipe: begin
        adj_we = 1'b1;
        if (idx_q == NW'(MAX_VERTICES - 1)) begin
          idx_d = '0; state_d = StIdle;
        end else idx_d = idx_q + NW'(1);
      end

      StIdle: begin
        in_ready_o = 1'b1;
        adj_raddr = AW'(end_a_i);
        if (in_valid_i) begin
          if (command_i == CmdAddEdge) begin
            ea_d = AW'(end_a_i); eb_d = AW'(end_b_i);
            edge_ok_d = (32'(end_a_i) < 32'(n_eff)) && (32'(end_b_i) < 32'(n_eff));
            state_d = StEdgeA;
          end else begin
            idx_d = '0; state_d = StRootScan;
          end
        end
      end

      // row A is in the read register; fetch row B meanwhile
      StEdgeA: begin
        adj_we = edge_ok_q; adj_waddr = ea_q;
        adj_wdata = adj_rdata_q | (Bit0 << eb_q);
        adj_raddr = eb_q;
        state_d = StEdgeB;
      end

      StEdgeB: begin
        adj_we = edge_ok_q; adj_waddr = eb_q;
        adj_wdata = adj_rdata_q | (Bit0 << ea_q);
        state_d = StIdle;
      end

      StRootScan: begin
        adj_raddr = idx_v;
        if (idx_q >= n_eff) begin
          idx_d = '0; state_d = StEmit;
        end else if (vis_q[idx_v]) idx_d = idx_q + NW'(1);
        else begin
          vis_d[idx_v] = 1'b1;
          cur_d = '{disc: VtxW'(time_q), low: VtxW'(time_q), parent: '0,
                    has_par: 1'b0, scan: '0, kids: 2'd0};
          time_d = time_q + CntW'(1);
          top_d = idx_v; state_d = StScan;
        end
      end

      // row of top_q is in adj_rdata_q
      StScan: begin
        if (|scan_cand) begin
          cur_d.scan = scan_next;
          if (!vis_q[f_scan]) begin
            // tree edge: park the top's record and step down
            rec_we = 1'b1; rec_wdata.scan = scan_next;
            vis_d[f_scan] = 1'b1;
            cur_d = '{disc: VtxW'(time_q), low: VtxW'(time_q), parent: top_q,
                      has_par: 1'b1, scan: '0, kids: 2'd0};
            time_d = time_q + CntW'(1);
            top_d = f_scan; adj_raddr = f_scan;
          end else begin
            rec_raddr = f_scan; chv_d = f_scan; state_d = StBack;
          end
        end else begin
          // vertex finished: its times stay readable for later back edges
          rec_we = 1'b1;
          if (cur_q.has_par) begin
            rec_raddr = cur_q.parent; adj_raddr = cur_q.parent;
            top_d = cur_q.parent; chd_low_d = cur_q.low;
            state_d = StFold;
          end else begin
            if (cur_q.kids == KidsMany && !cut_q[top_q]) begin
              cut_d[top_q] = 1'b1; cnt_d = cnt_q + CntW'(1);
            end
            state_d = StRootScan;
          end
        end
      end

      StBack: begin
        if (cur_q.low > disc_u) cur_d.low = disc_u;
        state_d = StScan;
      end

      // parent record arrives; fold the child's low time into it, count the child and flag a non-root parent as cut
      StFold: begin
        cur_d = rec_rdata_q;
        if (rec_rdata_q.low > chd_low_q) cur_d.low = chd_low_q;
        if (rec_rdata_q.kids != KidsMany) cur_d.kids = rec_rdata_q.kids + 2'd1;
        if (rec_rdata_q.has_par && chd_low_q >= rec_rdata_q.disc && !cut_q[top_q]) begin
          cut_d[top_q] = 1'b1; cnt_d = cnt_q + CntW'(1);
        end
        state_d = StScan;
      end

      StEmit: begin
        if (!ov_q || out_take) begin
          ov_d = 1'b1;
          if (cnt_q == '0) begin
            ocv_d = '0; ofd_d = 1'b0; ocnt_d = '0; olast_d = 1'b1;
          end else begin
            ocv_d = VtxW'(f_emit); ofd_d = 1'b1; ocnt_d = cnt_q;
            olast_d = ~|emit_rest;
            idx_d = NW'(f_emit) + NW'(1);
          end
          if (cnt_q == '0 || ~|emit_rest) begin
            vis_d = '0; cut_d = '0; time_d = '0; cnt_d = '0; idx_d = '0;
            state_d = StWipe;
          end
        end
      end

      default: ;
    endcase
  end

  assign out_valid_o  = ov_q;
  assign cut_vertex_o = ocv_q;
  assign found_o      = ofd_q;
  assign cut_count_o  = ocnt_q;
  assign last_o       = olast_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable({ocv_q, ofd_q, ocnt_q, olast_q}))
    else $error("beat dropped or changed");
  a_none_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !ofd_q |-> (ocnt_q == '0) && olast_q) else $error("bad empty beat");
  a_time_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(time_q) <= MAX_VERTICES) else $error("time counter overrun");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_VERTICES) else $error("cut count overrun");
`endif

endmodule

// ===== dv/tb_articulation_point_finder.sv =====
// Testbench for the articulation point finder: graph loading, cut vertex search and result stream.
module tb_articulation_point_finder;
  timeunit 1ns;
  timeprecision 1ps;

  import apf_pkg::*;

  localparam int unsigned RunLimit  = 2000000;  // cycles before we call it hung
  localparam int unsigned SettleCyc = 200;      // covers edge RMW and the post-run wipe
  localparam logic [7:0]  NoParent  = 8'hFF;

  typedef struct packed {
    logic [VtxW-1:0] cut_vertex;
    logic            found;
    logic [CntW-1:0] cut_count;
    logic            last;
  } cut_beat_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CntW-1:0] cfg_wdata_i;
  logic            in_valid_i;
  logic            in_ready_o;
  logic            command_i;
  logic [VtxW-1:0] end_a_i;
  logic [VtxW-1:0] end_b_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [VtxW-1:0] cut_vertex_o;
  logic            found_o;
  logic [CntW-1:0] cut_count_o;
  logic            last_o;

  articulation_point_finder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .end_a_i     (end_a_i),
    .end_b_i     (end_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cut_vertex_o(cut_vertex_o),
    .found_o     (found_o),
    .cut_count_o (cut_count_o),
    .last_o      (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow graph: adjacency rows, DFS bookkeeping and the vertex count register.
  // ---------------------------------------------------------------------------
  logic [63:0]     graph_rows [64];
  logic            seen       [64];
  logic            is_cut     [64];
  logic [5:0]      disc_t     [64];
  logic [5:0]      low_t      [64];
  logic [5:0]      dfs_stack  [64];
  logic [7:0]      parent_v   [64];
  logic [7:0]      scan_pos   [64];
  logic [7:0]      tree_kids  [64];
  logic [6:0]      stamp;
  logic [CntW-1:0] vcount_q;

  cut_beat_t cut_beats_q[$];   // beats still owed by the block

  int unsigned n_err;
  int unsigned n_beats;
  int unsigned n_edges;
  int unsigned n_runs;
  int unsigned n_items;
  bit          quiet;          // when set, neither side idles

  function automatic int unsigned live_vertices();
    return (vcount_q > MaxVertices) ? MaxVertices : int'(vcount_q);
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i < 64; i++) begin
      graph_rows[i] = '0;
      seen[i]       = 1'b0;
      is_cut[i]     = 1'b0;
    end
    stamp = '0;
  endfunction

  function automatic void discover(int unsigned v, logic [7:0] p);
    seen[v]      = 1'b1;
    disc_t[v]    = stamp[5:0];
    low_t[v]     = stamp[5:0];
    stamp        = stamp + 7'd1;
    parent_v[v]  = p;
    scan_pos[v]  = '0;
    tree_kids[v] = '0;
  endfunction

  // Iterative DFS from one root; each step either advances one neighbor of the
  // top vertex or retires it and folds its low time into its parent, if any.
  function automatic void dfs_from(int unsigned root, int unsigned n, logic [63:0] mask);
    int unsigned sp;
    int unsigned v;
    int unsigned u;
    int unsigned p;
    logic [63:0] row;
    bit          adv;
    sp = 0;
    discover(root, NoParent);
    dfs_stack[0] = root[5:0];
    sp = 1;
    while (sp > 0) begin
      v   = dfs_stack[sp-1];
      row = graph_rows[v] & mask;
      u   = scan_pos[v];
      adv = 1'b0;
      while (u < n && !adv) begin
        if (row[u] && u != parent_v[v]) begin
          scan_pos[v] = 8'(u + 1);
          if (!seen[u]) begin
            discover(u, v[7:0]);
            if (sp < 64) begin
              dfs_stack[sp] = u[5:0];
              sp++;
            end
          end else if (low_t[v] > disc_t[u]) begin
            low_t[v] = disc_t[u];
          end
          adv = 1'b1;
        end else begin
          u++;
        end
      end
      if (!adv) begin
        scan_pos[v] = n[7:0];
        sp--;
        if (parent_v[v] != NoParent) begin
          p = parent_v[v] & 8'h3F;
          if (low_t[p] > low_t[v]) low_t[p] = low_t[v];
          if (parent_v[p] != NoParent && low_t[v] >= disc_t[p]) is_cut[p] = 1'b1;
          if (tree_kids[p] < 8'd255) tree_kids[p] = tree_kids[p] + 8'd1;
        end else if (tree_kids[v] > 8'd1) begin
          is_cut[v] = 1'b1;
        end
      end
    end
  endfunction

  // Applies one accepted beat to the shadow graph; a run queues its result beats.
  function automatic void predict_cut_vertices(logic cmd, logic [5:0] a, logic [5:0] b);
    int unsigned n;
    int unsigned total;
    int unsigned k;
    logic [63:0] mask;
    cut_beat_t   bt;
    n    = live_vertices();
    mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    if (cmd == CmdAddEdge) begin
      if (a < n && b < n) begin
        graph_rows[a][b] = 1'b1;
        graph_rows[b][a] = 1'b1;
      end
      return;
    end
    for (int v = 0; v < n; v++)
      if (!seen[v]) dfs_from(v, n, mask);
    total = 0;
    for (int v = 0; v < n; v++)
      if (is_cut[v]) total++;
    if (total == 0) begin
      bt = '{cut_vertex: '0, found: 1'b0, cut_count: '0, last: 1'b1};
      cut_beats_q.insert(cut_beats_q.size(), bt);
    end else begin
      k = 0;
      for (int v = 0; v < n; v++) begin
        if (is_cut[v]) begin
          k++;
          bt = '{cut_vertex: v[5:0], found: 1'b1, cut_count: total[6:0],
                 last: (k == total)};
          cut_beats_q.insert(cut_beats_q.size(), bt);
        end
      end
    end
    wipe_graph();
  endfunction

  // Gap length: mostly none, sometimes short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one beat per call. Valid stays up between back-to-back beats.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic cmd, logic [5:0] a, logic [5:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    end_a_i    <= a;
    end_b_i    <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_cut_vertices(cmd, a, b);
    n_items++;
    if (cmd == CmdRun) n_runs++; else n_edges++;
  endtask

  task automatic add_edge(int unsigned a, int unsigned b);
    send_item(CmdAddEdge, a[5:0], b[5:0]);
  endtask

  task automatic run_search();
    send_item(CmdRun, 6'($urandom()), 6'($urandom()));  // endpoints are don't-care on a run
  endtask

  // Holds the sender off until every owed beat has arrived, then lets the wipe
  // or a trailing edge write finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (cut_beats_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_vcount(int unsigned val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val[CntW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    vcount_q     = val[CntW-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, then compare each beat to the oldest owed.
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(99) < 25) begin
      stall_left  <= ($urandom_range(99) < 90) ? $urandom_range(3, 1) : $urandom_range(60, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cut_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_beats++;
      if (cut_beats_q.size() == 0) begin
        $error("result beat with nothing owed: cut_vertex %0d", cut_vertex_o);
        n_err++;
      end else begin
        want = cut_beats_q.pop_front();
        if (cut_vertex_o !== want.cut_vertex) begin
          $error("cut_vertex: exp %0d got %0d", want.cut_vertex, cut_vertex_o);
          n_err++;
        end
        if (found_o !== want.found) begin
          $error("found: exp %0d got %0d", want.found, found_o);
          n_err++;
        end
        if (cut_count_o !== want.cut_count) begin
          $error("cut_count: exp %0d got %0d", want.cut_count, cut_count_o);
          n_err++;
        end
        if (last_o !== want.last) begin
          $error("last: exp %0d got %0d", want.last, last_o);
          n_err++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  int unsigned cyc;
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > RunLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-built graphs at the reset count of 64.
  task automatic test_directed();
    run_search();          // isolated vertices only: no cut vertex
    add_edge(0, 1);        // path 0-1-2, with a repeated edge and a self loop
    add_edge(1, 2);
    add_edge(2, 1);
    add_edge(2, 2);
    run_search();          // vertex 1
    add_edge(0, 63);       // star: the root alone is the cut
    add_edge(0, 62);
    add_edge(5, 0);
    run_search();
    add_edge(10, 11);      // triangle: none
    add_edge(11, 12);
    add_edge(12, 10);
    run_search();
    add_edge(63, 62);      // top-end path
    add_edge(62, 61);
    run_search();
  endtask

  // Register extremes: small count with ignored endpoints, zero, saturation, one.
  task automatic test_vertex_count();
    write_vcount(5);
    add_edge(10, 2);       // out of range: dropped
    add_edge(4, 3);
    add_edge(3, 2);
    add_edge(2, 5);        // b equals count: dropped
    run_search();
    write_vcount(0);       // empty graph
    add_edge(0, 0);
    run_search();
    write_vcount(127);     // saturates to 64
    add_edge(63, 62);
    add_edge(62, 61);
    run_search();
    write_vcount(1);
    add_edge(0, 0);
    run_search();
  endtask

  // Load a long path at full size, then shrink the count before the run.
  task automatic test_count_lowered();
    write_vcount(64);
    for (int i = 0; i < 9; i++) add_edge(i, i + 1);
    write_vcount(4);       // only 0..3 remain: cuts 1 and 2
    run_search();
  endtask

  // Random graphs: mostly trees and sparse graphs inside range, some noise.
  task automatic test_random_graphs(int unsigned budget);
    int unsigned n;
    int unsigned edges;
    int unsigned style;
    int unsigned start;
    int unsigned a;
    int unsigned b;
    start = n_items;
    while (n_items - start < budget) begin
      if ($urandom_range(99) < 35) begin
        case ($urandom_range(9))
          0:       write_vcount($urandom_range(127, 65));
          1:       write_vcount($urandom_range(1, 0));
          2, 3:    write_vcount(64);
          default: write_vcount($urandom_range(20, 2));
        endcase
        quiet = ($urandom_range(4) == 0);
      end
      n     = live_vertices();
      style = $urandom_range(9);
      edges = (n < 2) ? $urandom_range(3) : $urandom_range((n > 24) ? 24 : n + 2, 1);
      for (int e = 0; e < edges; e++) begin
        if (style < 5 && n >= 2) begin
          b = $urandom_range(n - 1, 1);      // tree-ish: attach to a lower vertex
          a = $urandom_range(b - 1);
        end else if (style < 8) begin
          a = $urandom_range(63);
          b = (n > 0) ? $urandom_range(n - 1) : $urandom_range(63);
          if (n > 0 && $urandom_range(3) != 0) a = $urandom_range(n - 1);
        end else begin
          a = $urandom_range(63);            // noise
          b = $urandom_range(63);
        end
        if ($urandom_range(1)) add_edge(a, b); else add_edge(b, a);
      end
      run_search();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    command_i   = CmdAddEdge;
    end_a_i     = '0;
    end_b_i     = '0;
    out_ready_i = 1'b0;
    stall_left  = 0;
    quiet       = 1'b0;
    cyc         = 0;
    n_err       = 0;
    n_beats     = 0;
    n_edges     = 0;
    n_runs      = 0;
    n_items     = 0;
    vcount_q    = 7'd64;
    wipe_graph();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_vertex_count();
    test_count_lowered();
    test_random_graphs(400);

    drain();
    $display("covered %0d edge beats and %0d searches, %0d result beats checked",
             n_edges, n_runs, n_beats);
    $display("vertex counts from 0 to 127, with idle and stall gaps on both sides");
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/apf_pkg.sv
rtl/core/articulation_point_finder.sv
dv/tb_articulation_point_finder.sv
